// ===== rtl/slwe_pkg.sv =====
// shared types, widths, codes and saturation helper for the sparse linear weight engine
package slwe_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 10;
	localparam int VAL_W     = 32;
	localparam int ACT_W     = 11;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// arithmetic widths
	localparam int ACC_W    = 48;
	localparam int HALF_W   = 24;
	localparam int NARROW_W = 32;
	localparam int FRAC_W   = 16;
	localparam int DOT_W    = 32;
	localparam int SAT_W    = 64;
	localparam int PROD_W   = SAT_W + FRAC_W;

	// command queue depth
	localparam int Q_DEPTH = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REG = 2'd1;

	// item kinds
	typedef enum logic [KIND_W-1:0] {
		OP_DOT   = 2'd0,
		OP_UPD   = 2'd1,
		OP_SCALE = 2'd2
	} op_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DOT_MUL,
		ST_DOT_WAIT,
		ST_UPD_M1,
		ST_UPD_M2,
		ST_UPD_T1,
		ST_UPD_T2,
		ST_UPD_M3,
		ST_UPD_T3,
		ST_UPD_WR,
		ST_FINISH,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// classified item as queued between front and back
	typedef struct packed {
		op_t                      op;
		logic                     in_store;
		logic [IDX_W-1:0]         index;
		logic signed [VAL_W-1:0]  value;
		logic signed [VAL_W-1:0]  reward;
		logic                     last;
		logic                     ratio_zero;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [KIND_W-1:0]        done_kind;
		logic signed [DOT_W-1:0]  dot_sum;
		logic [ACT_W-1:0]         active_weights;
		logic                     saturated;
	} result_t;

	// saturated value with clip flag
	typedef struct packed {
		logic signed [SAT_W-1:0] v;
		logic                    clip;
	} sat_t;

	// clip a signed value to a two's complement range of the given width
	function automatic sat_t sat_to(input logic signed [SAT_W-1:0] x, input int unsigned bits);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		sat_t r;
		hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		r.v = x;
		r.clip = 1'b0;
		if (x > hi) begin
			r.v = hi;
			r.clip = 1'b1;
		end else if (x < lo) begin
			r.v = lo;
			r.clip = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/slwe_if.sv =====
// item and result channel interfaces with valid/ready handshake
interface slwe_in_if;
	logic                              valid;
	logic                              ready;
	logic [slwe_pkg::KIND_W-1:0]       kind;
	logic [slwe_pkg::IDX_W-1:0]        index;
	logic signed [slwe_pkg::VAL_W-1:0] value;
	logic signed [slwe_pkg::VAL_W-1:0] reward;
	logic                              last;

	modport source(output valid, kind, index, value, reward, last, input ready);
	modport sink(input valid, kind, index, value, reward, last, output ready);
endinterface

interface slwe_out_if;
	logic                              valid;
	logic                              ready;
	logic [slwe_pkg::KIND_W-1:0]       done_kind;
	logic signed [slwe_pkg::DOT_W-1:0] dot_sum;
	logic [slwe_pkg::ACT_W-1:0]        active_weights;
	logic                              saturated;

	modport source(output valid, done_kind, dot_sum, active_weights, saturated, input ready);
	modport sink(input valid, done_kind, dot_sum, active_weights, saturated, output ready);
endinterface

// ===== rtl/slwe_ram.sv =====
// generic single write port, single read port ram with registered read
module slwe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/slwe_mul.sv =====
// five stage fixed point multiplier: floor(a*b / 2^16) saturated to 48 or weight bits
module slwe_mul #(
	parameter int WEIGHT_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic signed [slwe_pkg::ACC_W-1:0]    a,
	input  logic signed [slwe_pkg::NARROW_W-1:0] b,
	input  logic                                 wide,
	output logic                                 valid,
	output logic signed [slwe_pkg::ACC_W-1:0]    res,
	output logic                                 clip
);

	localparam int AW_ = slwe_pkg::ACC_W;
	localparam int HW  = slwe_pkg::HALF_W;
	localparam int BW  = slwe_pkg::NARROW_W;
	localparam int PW  = slwe_pkg::PROD_W;
	localparam int FW  = slwe_pkg::FRAC_W;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    wide_s1, wide_s2, wide_s3, wide_s4;
	logic signed [AW_-1:0]   a_s1;
	logic signed [BW-1:0]    b_s1, b_s2;
	logic signed [HW+BW:0]   p_lo_s2, p_lo_s3;
	logic signed [HW-1:0]    hi_s2;
	logic signed [HW+BW-1:0] p_hi_s3;
	logic signed [PW-1:0]    full_s4;
	logic signed [slwe_pkg::SAT_W-1:0] prod_sh;
	slwe_pkg::sat_t          sat_wide, sat_narrow, sat_sel;

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			valid <= 1'b0;
		end else begin
			v_s1  <= go;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			valid <= v_s4;
		end
	end

	// shift and clip of the full product
	assign prod_sh    = $signed(full_s4[PW-1:FW]);
	assign sat_wide   = slwe_pkg::sat_to(prod_sh, AW_);
	assign sat_narrow = slwe_pkg::sat_to(prod_sh, WEIGHT_BITS);
	assign sat_sel    = wide_s4 ? sat_wide : sat_narrow;

	// operand capture, low and high partial products, sum, clip
	always_ff @(posedge clk) begin
		a_s1    <= a;
		b_s1    <= b;
		wide_s1 <= wide;

		p_lo_s2 <= $signed({1'b0, a_s1[HW-1:0]}) * b_s1;
		hi_s2   <= a_s1[AW_-1:HW];
		b_s2    <= b_s1;
		wide_s2 <= wide_s1;

		p_hi_s3 <= hi_s2 * b_s2;
		p_lo_s3 <= p_lo_s2;
		wide_s3 <= wide_s2;

		full_s4 <= (PW'(p_hi_s3) <<< HW) + PW'(p_lo_s3);
		wide_s4 <= wide_s3;

		res     <= sat_sel.v[AW_-1:0];
		clip    <= sat_sel.clip;
	end

endmodule

// ===== rtl/slwe_front.sv =====
// front end: accepts items, drops unknown kinds and classifies the rest for the queue
module slwe_front #(
	parameter int WEIGHT_DEPTH = 1024
) (
	slwe_in_if.sink         items,
	input  logic            q_full,
	input  logic            init_busy,
	output logic            push,
	output slwe_pkg::cmd_t  cmd
);

	logic kind_ok;

	// kind decode
	always_comb begin
		unique case (items.kind)
			slwe_pkg::OP_DOT,
			slwe_pkg::OP_UPD,
			slwe_pkg::OP_SCALE: kind_ok = 1'b1;
			default:            kind_ok = 1'b0;
		endcase
	end

	// no item taken while the store is being cleared after reset
	assign items.ready = !q_full && !init_busy;
	assign push        = items.valid && items.ready && kind_ok;

	// classified command
	always_comb begin
		cmd.op         = slwe_pkg::op_t'(items.kind);
		cmd.in_store   = (32'(items.index) < WEIGHT_DEPTH);
		cmd.index      = items.index;
		cmd.value      = items.value;
		cmd.reward     = items.reward;
		cmd.last       = items.last;
		cmd.ratio_zero = (items.value == '0);
	end

endmodule

// ===== rtl/slwe_queue.sv =====
// short command queue between front and back
module slwe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slwe_pkg::cmd_t wdata,
	output logic           full,
	output logic           valid,
	output slwe_pkg::cmd_t head,
	input  logic           pop
);

	localparam int PTR_W = $clog2(slwe_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(slwe_pkg::Q_DEPTH + 1);

	slwe_pkg::cmd_t   mem_q [slwe_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full   = (cnt_q == CNT_W'(slwe_pkg::Q_DEPTH));
	assign valid  = (cnt_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/slwe_back.sv =====
// back end: sequencer over the weight ram and the shared multiplier, result register
module slwe_back #(
	parameter int WEIGHT_DEPTH = 1024,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  slwe_pkg::cmd_t               head,
	output logic                         pop,
	input  logic [slwe_pkg::CFG_W-1:0]   lr,
	input  logic [slwe_pkg::CFG_W-1:0]   regularization,
	output logic                         init_busy,
	slwe_out_if.source                   results
);

	localparam int AW        = $clog2(WEIGHT_DEPTH);
	localparam int CNT_W     = AW + 1;
	localparam int ACC_W     = slwe_pkg::ACC_W;
	localparam int NW        = slwe_pkg::NARROW_W;
	localparam int ACT_W     = slwe_pkg::ACT_W;
	localparam int IDX_W     = slwe_pkg::IDX_W;
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WEIGHT_DEPTH);
	localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(WEIGHT_DEPTH - 1);

	// sequencer and architectural state
	slwe_pkg::state_t         state_q, state_d;
	logic [ACT_W-1:0]         act_q, act_d;
	logic [IDX_W-1:0]         lnz_q, lnz_d;
	logic                     clip_q, clip_d;
	logic signed [ACC_W-1:0]  acc_q, acc_d;
	logic                     init_q, init_d;
	logic                     clr_emit_q, clr_emit_d;
	logic [CNT_W-1:0]         rd_cnt_q, rd_cnt_d;
	logic [CNT_W-1:0]         wr_cnt_q, wr_cnt_d;
	logic                     rd_pend_q;
	logic                     out_valid_q, out_valid_d;

	// item payload registers
	slwe_pkg::cmd_t               cur_q, cur_d;
	logic signed [WEIGHT_BITS-1:0] w_q, w_d;
	logic signed [ACC_W-1:0]      t1_q, t1_d;
	logic signed [ACC_W-1:0]      d_q, d_d;
	logic signed [ACC_W-1:0]      delta_q, delta_d;
	slwe_pkg::result_t            out_q, out_d;

	// ram and multiplier hookup
	logic                          rd_en, wr_en;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic [WEIGHT_BITS-1:0]        wr_data, rd_data;
	logic signed [WEIGHT_BITS-1:0] rd_w;
	logic                          mul_go, mul_wide, mul_valid, mul_clip;
	logic signed [ACC_W-1:0]       mul_a, mul_res;
	logic signed [NW-1:0]          mul_b;

	// saturating adders
	slwe_pkg::sat_t sum_sat, diff_sat, w_sat, dot_sat;
	logic           slot_free;
	logic           is_dot;

	slwe_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (WEIGHT_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	slwe_mul #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go),
		.a      (mul_a),
		.b      (mul_b),
		.wide   (mul_wide),
		.valid  (mul_valid),
		.res    (mul_res),
		.clip   (mul_clip)
	);

	assign rd_w      = $signed(rd_data);
	assign init_busy = init_q;
	assign slot_free = !out_valid_q || results.ready;
	assign is_dot    = (cur_q.op == slwe_pkg::OP_DOT);

	assign sum_sat  = slwe_pkg::sat_to(64'(acc_q) + 64'(mul_res), ACC_W);
	assign diff_sat = slwe_pkg::sat_to(64'(t1_q) - 64'(mul_res), ACC_W);
	assign w_sat    = slwe_pkg::sat_to(64'(w_q) + 64'(delta_q), WEIGHT_BITS);
	assign dot_sat  = slwe_pkg::sat_to(64'(acc_q), slwe_pkg::DOT_W);

	// result channel
	assign results.valid          = out_valid_q;
	assign results.done_kind      = out_q.done_kind;
	assign results.dot_sum        = out_q.dot_sum;
	assign results.active_weights = out_q.active_weights;
	assign results.saturated      = out_q.saturated;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slwe_pkg::ST_CLEAR;
			act_q       <= '0;
			lnz_q       <= '0;
			clip_q      <= 1'b0;
			acc_q       <= '0;
			init_q      <= 1'b1;
			clr_emit_q  <= 1'b0;
			rd_cnt_q    <= '0;
			wr_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			act_q       <= act_d;
			lnz_q       <= lnz_d;
			clip_q      <= clip_d;
			acc_q       <= acc_d;
			init_q      <= init_d;
			clr_emit_q  <= clr_emit_d;
			rd_cnt_q    <= rd_cnt_d;
			wr_cnt_q    <= wr_cnt_d;
			rd_pend_q   <= rd_en;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		w_q     <= w_d;
		t1_q    <= t1_d;
		d_q     <= d_d;
		delta_q <= delta_d;
		out_q   <= out_d;
	end

	// next state and datapath control
	always_comb begin
		state_d     = state_q;
		act_d       = act_q;
		lnz_d       = lnz_q;
		clip_d      = clip_q;
		acc_d       = acc_q;
		init_d      = init_q;
		clr_emit_d  = clr_emit_q;
		rd_cnt_d    = rd_cnt_q;
		wr_cnt_d    = wr_cnt_q;
		out_valid_d = out_valid_q && !results.ready;
		cur_d       = cur_q;
		w_d         = w_q;
		t1_d        = t1_q;
		d_d         = d_q;
		delta_d     = delta_q;
		out_d       = out_q;
		pop         = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = AW'(head.index);
		wr_en       = 1'b0;
		wr_addr     = wr_cnt_q[AW-1:0];
		wr_data     = '0;
		mul_go      = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		mul_wide    = 1'b1;

		unique case (state_q)
			// zero the store one entry a cycle
			slwe_pkg::ST_CLEAR: begin
				wr_en    = 1'b1;
				wr_addr  = wr_cnt_q[AW-1:0];
				wr_data  = '0;
				wr_cnt_d = wr_cnt_q + CNT_W'(1);
				if (wr_cnt_q == LAST_CNT) begin
					init_d  = 1'b0;
					state_d = clr_emit_q ? slwe_pkg::ST_EMIT : slwe_pkg::ST_IDLE;
				end
			end

			// take the next command and start its work
			slwe_pkg::ST_IDLE: begin
				if (q_valid) begin
					pop   = 1'b1;
					cur_d = head;
					unique case (head.op)
						slwe_pkg::OP_DOT: begin
							if (head.in_store && (ACT_W'(head.index) < act_q)) begin
								rd_en   = 1'b1;
								state_d = slwe_pkg::ST_DOT_MUL;
							end else if (head.last) begin
								state_d = slwe_pkg::ST_EMIT;
							end
						end
						slwe_pkg::OP_UPD: begin
							if (head.in_store) begin
								rd_en   = 1'b1;
								state_d = slwe_pkg::ST_UPD_M1;
							end else if (head.last) begin
								state_d = slwe_pkg::ST_FINISH;
							end
						end
						slwe_pkg::OP_SCALE: begin
							if (act_q != '0) begin
								wr_cnt_d = '0;
								if (head.ratio_zero) begin
									clr_emit_d = 1'b1;
									state_d    = slwe_pkg::ST_CLEAR;
								end else begin
									rd_cnt_d = '0;
									state_d  = slwe_pkg::ST_SCALE;
								end
							end else begin
								state_d = slwe_pkg::ST_EMIT;
							end
						end
						default: ;
					endcase
				end
			end

			// feature value times weight
			slwe_pkg::ST_DOT_MUL: begin
				mul_go   = 1'b1;
				mul_a    = ACC_W'(rd_w);
				mul_b    = cur_q.value;
				mul_wide = 1'b1;
				state_d  = slwe_pkg::ST_DOT_WAIT;
			end

			// accumulate the term
			slwe_pkg::ST_DOT_WAIT: begin
				if (mul_valid) begin
					acc_d   = sum_sat.v[ACC_W-1:0];
					clip_d  = clip_q | mul_clip | sum_sat.clip;
					state_d = cur_q.last ? slwe_pkg::ST_EMIT : slwe_pkg::ST_IDLE;
				end
			end

			// reward times trace
			slwe_pkg::ST_UPD_M1: begin
				w_d      = rd_w;
				mul_go   = 1'b1;
				mul_a    = ACC_W'(cur_q.reward);
				mul_b    = cur_q.value;
				mul_wide = 1'b1;
				state_d  = slwe_pkg::ST_UPD_M2;
			end

			// decay times weight
			slwe_pkg::ST_UPD_M2: begin
				mul_go   = 1'b1;
				mul_a    = ACC_W'(w_q);
				mul_b    = NW'(regularization);
				mul_wide = 1'b1;
				state_d  = slwe_pkg::ST_UPD_T1;
			end

			slwe_pkg::ST_UPD_T1: begin
				if (mul_valid) begin
					t1_d    = mul_res;
					clip_d  = clip_q | mul_clip;
					state_d = slwe_pkg::ST_UPD_T2;
				end
			end

			// difference of the two terms
			slwe_pkg::ST_UPD_T2: begin
				if (mul_valid) begin
					d_d     = diff_sat.v[ACC_W-1:0];
					clip_d  = clip_q | mul_clip | diff_sat.clip;
					state_d = slwe_pkg::ST_UPD_M3;
				end
			end

			// step size times difference
			slwe_pkg::ST_UPD_M3: begin
				mul_go   = 1'b1;
				mul_a    = d_q;
				mul_b    = NW'(lr);
				mul_wide = 1'b1;
				state_d  = slwe_pkg::ST_UPD_T3;
			end

			slwe_pkg::ST_UPD_T3: begin
				if (mul_valid) begin
					delta_d = mul_res;
					clip_d  = clip_q | mul_clip;
					state_d = slwe_pkg::ST_UPD_WR;
				end
			end

			// write back the new weight and track the last nonzero index
			slwe_pkg::ST_UPD_WR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(cur_q.index);
				wr_data = w_sat.v[WEIGHT_BITS-1:0];
				clip_d  = clip_q | w_sat.clip;
				if (w_sat.v != '0) begin
					lnz_d = cur_q.index;
				end
				state_d = cur_q.last ? slwe_pkg::ST_FINISH : slwe_pkg::ST_IDLE;
			end

			// end of an update run
			slwe_pkg::ST_FINISH: begin
				act_d   = ACT_W'(lnz_q) + ACT_W'(1);
				lnz_d   = '0;
				state_d = slwe_pkg::ST_EMIT;
			end

			// streamed read, multiply and write over the whole store
			slwe_pkg::ST_SCALE: begin
				if (rd_cnt_q < DEPTH_CNT) begin
					rd_en    = 1'b1;
					rd_addr  = rd_cnt_q[AW-1:0];
					rd_cnt_d = rd_cnt_q + CNT_W'(1);
				end
				if (rd_pend_q) begin
					mul_go   = 1'b1;
					mul_a    = ACC_W'(rd_w);
					mul_b    = cur_q.value;
					mul_wide = 1'b0;
				end
				if (mul_valid) begin
					wr_en    = 1'b1;
					wr_addr  = wr_cnt_q[AW-1:0];
					wr_data  = mul_res[WEIGHT_BITS-1:0];
					clip_d   = clip_q | mul_clip;
					wr_cnt_d = wr_cnt_q + CNT_W'(1);
					if (wr_cnt_q == LAST_CNT) begin
						state_d = slwe_pkg::ST_EMIT;
					end
				end
			end

			// load the result register once it is free
			slwe_pkg::ST_EMIT: begin
				if (slot_free) begin
					out_valid_d          = 1'b1;
					out_d.done_kind      = cur_q.op;
					out_d.dot_sum        = is_dot ? dot_sat.v[slwe_pkg::DOT_W-1:0] : '0;
					out_d.active_weights = act_q;
					out_d.saturated      = clip_q | (is_dot & dot_sat.clip);
					clip_d               = 1'b0;
					clr_emit_d           = 1'b0;
					if (is_dot) begin
						acc_d = '0;
					end
					state_d = slwe_pkg::ST_IDLE;
				end
			end

			default: state_d = slwe_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/sparse_linear_weight_engine_top.sv =====
// top level: configuration registers, front end, command queue and back end
// flow: the back end works on one item at a time while the queue holds later ones;
// it is paced by the shared five stage multiplier and the single read port of the
// weight ram, and a zero scale ratio clears the whole store instead of scaling it
// reset: after arst_n the weight ram is zeroed one entry a cycle, with items not accepted
// meanwhile; configuration writes are taken throughout
module sparse_linear_weight_engine_top #(
	parameter int WEIGHT_DEPTH = 1024,
	parameter int WEIGHT_BITS  = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	slwe_in_if.sink                          items,
	slwe_out_if.source                       results,
	input  logic                             cfg_wen,
	input  logic [slwe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slwe_pkg::CFG_W-1:0]       cfg_wdata
);

	logic [slwe_pkg::CFG_W-1:0] lr_q, reg_q;
	logic                       push, q_full, q_valid, pop, init_busy;
	slwe_pkg::cmd_t             cmd, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= '0;
			reg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				slwe_pkg::CFG_LR:  lr_q  <= cfg_wdata;
				slwe_pkg::CFG_REG: reg_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	slwe_front #(
		.WEIGHT_DEPTH (WEIGHT_DEPTH)
	) u_front (
		.items     (items),
		.q_full    (q_full),
		.init_busy (init_busy),
		.push      (push),
		.cmd       (cmd)
	);

	slwe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (q_full),
		.valid  (q_valid),
		.head   (head),
		.pop    (pop)
	);

	slwe_back #(
		.WEIGHT_DEPTH (WEIGHT_DEPTH),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.head           (head),
		.pop            (pop),
		.lr             (lr_q),
		.regularization (reg_q),
		.init_busy      (init_busy),
		.results        (results)
	);

endmodule
